// File: rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types, widths and register indexes for the affine box transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aat_pkg;

  localparam int QW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * QW;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;
  localparam int NUM_AXES  = 3;
  localparam int NUM_STAGES = 5;
  localparam int IDX_W     = 3;
  localparam int IN_W      = 4 * NUM_AXES * QW;
  localparam int OUT_W     = 2 * NUM_AXES * QW;

  typedef logic signed [QW-1:0]     q_t;
  typedef logic        [QW-1:0]     q_bits_t;
  typedef q_bits_t     [NUM_AXES-1:0] q3_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_en_t;

  localparam logic [IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  localparam sum_t SAT_HI = sum_t'(34'sh0_7FFF_FFFF);
  localparam sum_t SAT_LO = -sum_t'(34'sh0_8000_0000);

  function automatic q_bits_t sat_q(input sum_t v);
    q_bits_t r;
    if (v > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/aat_lane.sv
// ----------------------------------------------------------------------------
// aat_lane
// Datapath for one world axis: multiply, floor shift, min/max sort,
// wide sum and saturation over five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aat_lane (
  input  wire                  clk,
  input  aat_pkg::stage_en_t   en,
  input  aat_pkg::q3_t         basis,
  input  aat_pkg::q_bits_t     offset,
  input  aat_pkg::q3_t         box_lo,
  input  aat_pkg::q3_t         box_hi,
  output aat_pkg::q_bits_t     world_min,
  output aat_pkg::q_bits_t     world_max
);
  import aat_pkg::*;

  // stage 0: captured word
  q3_t     m0;
  q_bits_t off0;
  // stage 1: raw products
  prod_t   p_lo1 [NUM_AXES];
  prod_t   p_hi1 [NUM_AXES];
  q_bits_t off1;
  // stage 2: sorted truncated terms
  term_t   t_min2 [NUM_AXES];
  term_t   t_max2 [NUM_AXES];
  q_bits_t off2;
  // stage 3: wide sums
  sum_t    s_min3;
  sum_t    s_max3;
  // stage 4: saturated output
  q_bits_t w_min4;
  q_bits_t w_max4;

  term_t   e_t [NUM_AXES];
  term_t   f_t [NUM_AXES];

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      e_t[j] = p_lo1[j][PROD_W-1:FRAC_BITS];
      f_t[j] = p_hi1[j][PROD_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en.load[0]) begin
      m0   <= basis;
      off0 <= offset;
    end
    if (en.load[1]) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        p_lo1[j] <= prod_t'($signed(m0[j])) * prod_t'($signed(box_lo[j]));
        p_hi1[j] <= prod_t'($signed(m0[j])) * prod_t'($signed(box_hi[j]));
      end
      off1 <= off0;
    end
    if (en.load[2]) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        if (e_t[j] < f_t[j]) begin
          t_min2[j] <= e_t[j];
          t_max2[j] <= f_t[j];
        end else begin
          t_min2[j] <= f_t[j];
          t_max2[j] <= e_t[j];
        end
      end
      off2 <= off1;
    end
    if (en.load[3]) begin
      s_min3 <= sum_t'($signed(off2)) + sum_t'(t_min2[0]) + sum_t'(t_min2[1])
              + sum_t'(t_min2[2]);
      s_max3 <= sum_t'($signed(off2)) + sum_t'(t_max2[0]) + sum_t'(t_max2[1])
              + sum_t'(t_max2[2]);
    end
    if (en.load[4]) begin
      w_min4 <= sat_q(s_min3);
      w_max4 <= sat_q(s_max3);
    end
  end

  assign world_min = w_min4;
  assign world_max = w_max4;

endmodule

`default_nettype wire

// File: rtl/affine_aabb_transform_unit.sv
// ----------------------------------------------------------------------------
// affine_aabb_transform_unit
// Encloses a fixed local box, transformed by one affine matrix per word,
// in a world-space axis-aligned box (signed Q16.16, saturated).
// ----------------------------------------------------------------------------
// usage:
//   load the six local box bounds through cfg_we / cfg_index / cfg_data
//   while no word is in flight (index 0..2 min x,y,z, 3..5 max x,y,z;
//   other indexes are ignored)
//   s_tdata carries one matrix per word: three basis vectors, then the
//   translation; m_tdata returns the world min and max
//   pipeline: an accepted word reaches m_tvalid through five register
//   stages (capture, multiply, sort, sum, saturate); each stage holds its own
//   valid bit; throughput: one word per cycle unless m_tready stalls the pipe
//   stall: a stage loads only when empty or when the stage after it moves,
//   so a held m_tready fills the pipe and then drops s_tready; nothing
//   is lost or repeated
//   reset: rst empties the pipe and clears the box registers to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module affine_aabb_transform_unit (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [aat_pkg::IDX_W-1:0]  cfg_index,
  input  wire [aat_pkg::QW-1:0]     cfg_data,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  // basis0_x, basis0_y, basis0_z, basis1_x, basis1_y, basis1_z,
  // basis2_x, basis2_y, basis2_z, offset_x, offset_y, offset_z
  input  wire [aat_pkg::IN_W-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire                       m_tready,
  // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y,
  // world_max_z
  output logic [aat_pkg::OUT_W-1:0] m_tdata
);
  import aat_pkg::*;

  q3_t                   box_lo;
  q3_t                   box_hi;
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] ready;
  stage_en_t             en;
  q_bits_t               w_min [NUM_AXES];
  q_bits_t               w_max [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo <= '0;
      box_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  assign en.load = ready;
  assign s_tready = ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    q3_t basis_col;
    for (genvar j = 0; j < NUM_AXES; j++) begin : g_col
      assign basis_col[j] = s_tdata[(j*NUM_AXES+i)*QW +: QW];
    end
    aat_lane u_lane (
      .clk       (clk),
      .en        (en),
      .basis     (basis_col),
      .offset    (s_tdata[(NUM_AXES*NUM_AXES+i)*QW +: QW]),
      .box_lo    (box_lo),
      .box_hi    (box_hi),
      .world_min (w_min[i]),
      .world_max (w_max[i])
    );
    assign m_tdata[i*QW +: QW]            = w_min[i];
    assign m_tdata[(NUM_AXES+i)*QW +: QW] = w_max[i];
  end

  assign m_tvalid = valid[NUM_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/aat_chk.sv
// ----------------------------------------------------------------------------
// aat_chk
// Port-level checks for the affine box transform, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aat_chk (
  input wire                       clk,
  input wire                       rst,
  input wire                       s_tready,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [aat_pkg::OUT_W-1:0]  m_tdata
);
  import aat_pkg::*;

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled word changed");

  // an empty or draining output stage lets input in
  a_ready_chain: assert property (@(posedge clk)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output free");

  // world box is never inverted
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      ($signed(m_tdata[QW-1:0]) <= $signed(m_tdata[4*QW-1:3*QW])) &&
      ($signed(m_tdata[2*QW-1:QW]) <= $signed(m_tdata[5*QW-1:4*QW])) &&
      ($signed(m_tdata[3*QW-1:2*QW]) <= $signed(m_tdata[6*QW-1:5*QW])))
    else $error("world min above max");

endmodule

bind affine_aabb_transform_unit aat_chk u_aat_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
